// ===== hdl/dsw_pkg.sv =====
package dsw_pkg;

  localparam int ElevW       = 16;
  localparam int CountW      = 32;
  localparam int HistBins    = 19;
  localparam int BinW        = 5;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int FracW       = 16;
  localparam int NumW        = 36;
  localparam int MagW        = NumW - 1;
  localparam int DvdW        = MagW + FracW;
  localparam int DenW        = 36;
  localparam int GradW       = 34;
  localparam int ScW         = 31;
  localparam int SqW         = 2 * ScW;
  localparam int RadW        = SqW + 1;
  localparam int RootSteps   = 32;
  localparam int XW          = 36;
  localparam int ZW          = 25;
  localparam int CordicSteps = 20;
  localparam int CntW        = 6;
  localparam int QDepth      = 2;
  localparam int QPtrW       = 1;
  localparam int DegW        = 14;
  localparam int PctW        = 15;

  localparam logic [16:0] UnitQ16   = 17'd65536;
  localparam logic [17:0] Sqrt2Q16  = 18'd92682;
  localparam logic [15:0] Rsqrt2Q16 = 16'd46341;
  localparam logic [18:0] FdwrdDen  = 19'd447508;
  localparam logic [22:0] Deg90Q16  = 23'd5898240;
  localparam logic [17:0] Recip9    = 18'd233017;
  localparam logic [BinW-1:0] BinTop = 5'd18;

  localparam logic [ZW-1:0] AtanDegQ16 [CordicSteps] = '{
    25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379,
    25'd117304, 25'd58666, 25'd29335, 25'd14668, 25'd7334,
    25'd3667, 25'd1833, 25'd917, 25'd458, 25'd229,
    25'd115, 25'd57, 25'd29, 25'd14, 25'd7
  };

  typedef enum logic [3:0] {
    METH_SSM     = 4'd1,
    METH_2FD     = 4'd2,
    METH_3FDWRD  = 4'd3,
    METH_3FD     = 4'd4,
    METH_HORN    = 4'd5,
    METH_FFD     = 4'd6,
    METH_MAXDROP = 4'd7,
    METH_SIMPLE  = 4'd8,
    METH_QUAD    = 4'd9
  } method_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_METHOD    = 2'd0,
    CFG_SPACING_X = 2'd1,
    CFG_SPACING_Y = 2'd2,
    CFG_NULL_ELEV = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIV, BK_SCALE, BK_SUM, BK_ROOT, BK_ROT, BK_CLAMP, BK_MAP, BK_HIST
  } bk_state_e;

  typedef struct packed {
    logic            is_null;
    logic [DvdW-1:0] dvd_x;
    logic [DvdW-1:0] dvd_y;
    logic [DenW-1:0] den_x;
    logic [DenW-1:0] den_y;
  } dsw_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/dem_slope_window.sv =====
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    cell_1_i .. cell_9_i
// out       out_valid_o / out_ready_i  slope_degrees_o, slope_percent_o, slope_class_o,
//                                      hist_bin_o, bin_count_o, is_null_o
// cfg       cfg_we_i                   cfg_index_i, cfg_data_i
//
// In the back end a window takes 51 divider steps, SCALE and SUM, 32 square-root steps,
// 20 CORDIC steps when the root is nonzero, then CLAMP, MAP and HIST.
// A null centre goes straight from idle to HIST. The back end works one window at a time.
// Reset clears the histogram, queue and output beat; config registers return to defaults.
// A two-entry queue takes windows while the back end is busy; a waiting output beat
// stalls only the final histogram update.
module dem_slope_window import dsw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ElevW-1:0]    cell_1_i,
  input  logic [ElevW-1:0]    cell_2_i,
  input  logic [ElevW-1:0]    cell_3_i,
  input  logic [ElevW-1:0]    cell_4_i,
  input  logic [ElevW-1:0]    cell_5_i,
  input  logic [ElevW-1:0]    cell_6_i,
  input  logic [ElevW-1:0]    cell_7_i,
  input  logic [ElevW-1:0]    cell_8_i,
  input  logic [ElevW-1:0]    cell_9_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DegW-1:0]     slope_degrees_o,
  output logic [PctW-1:0]     slope_percent_o,
  output logic [2:0]          slope_class_o,
  output logic [BinW-1:0]     hist_bin_o,
  output logic [31:0]         bin_count_o,
  output logic                is_null_o
);

  q_status_t  q_st;
  logic       push, pop;
  dsw_entry_t f_entry, b_entry;

  dsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cell_1_i    (cell_1_i),
    .cell_2_i    (cell_2_i),
    .cell_3_i    (cell_3_i),
    .cell_4_i    (cell_4_i),
    .cell_5_i    (cell_5_i),
    .cell_6_i    (cell_6_i),
    .cell_7_i    (cell_7_i),
    .cell_8_i    (cell_8_i),
    .cell_9_i    (cell_9_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_st_i      (q_st),
    .push_o      (push),
    .entry_o     (f_entry)
  );

  dsw_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (f_entry),
    .pop_i    (pop),
    .entry_o  (b_entry),
    .status_o (q_st)
  );

  dsw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_st_i          (q_st),
    .entry_i         (b_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slope_degrees_o (slope_degrees_o),
    .slope_percent_o (slope_percent_o),
    .slope_class_o   (slope_class_o),
    .hist_bin_o      (hist_bin_o),
    .bin_count_o     (bin_count_o),
    .is_null_o       (is_null_o)
  );

endmodule

// ===== hdl/dsw_front.sv =====
module dsw_front import dsw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ElevW-1:0]    cell_1_i,
  input  logic [ElevW-1:0]    cell_2_i,
  input  logic [ElevW-1:0]    cell_3_i,
  input  logic [ElevW-1:0]    cell_4_i,
  input  logic [ElevW-1:0]    cell_5_i,
  input  logic [ElevW-1:0]    cell_6_i,
  input  logic [ElevW-1:0]    cell_7_i,
  input  logic [ElevW-1:0]    cell_8_i,
  input  logic [ElevW-1:0]    cell_9_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  q_status_t           q_st_i,
  output logic                push_o,
  output dsw_entry_t          entry_o
);

  logic [3:0]       method_q;
  logic [15:0]      spacing_x_q;
  logic [15:0]      spacing_y_q;
  logic [ElevW-1:0] null_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= METH_HORN;
      spacing_x_q <= 16'd1;
      spacing_y_q <= 16'd1;
      null_q      <= {1'b1, {(ElevW-1){1'b0}}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_METHOD:    method_q    <= cfg_data_i[3:0];
        CFG_SPACING_X: spacing_x_q <= cfg_data_i;
        CFG_SPACING_Y: spacing_y_q <= cfg_data_i;
        CFG_NULL_ELEV: null_q      <= cfg_data_i[ElevW-1:0];
        default:       null_q      <= null_q;
      endcase
    end
  end

  logic signed [NumW-1:0] e [9];
  logic [15:0]            sx, sy;
  logic signed [NumW-1:0] nx, ny;
  logic [NumW-1:0]        ax, ay;
  logic [DenW-1:0]        dx, dy;
  logic [NumW-1:0]        dk;
  logic [31:0]            vk, vmax;
  logic                   maxdrop;

  assign e[0] = {{(NumW-ElevW){cell_1_i[ElevW-1]}}, cell_1_i};
  assign e[1] = {{(NumW-ElevW){cell_2_i[ElevW-1]}}, cell_2_i};
  assign e[2] = {{(NumW-ElevW){cell_3_i[ElevW-1]}}, cell_3_i};
  assign e[3] = {{(NumW-ElevW){cell_4_i[ElevW-1]}}, cell_4_i};
  assign e[4] = {{(NumW-ElevW){cell_5_i[ElevW-1]}}, cell_5_i};
  assign e[5] = {{(NumW-ElevW){cell_6_i[ElevW-1]}}, cell_6_i};
  assign e[6] = {{(NumW-ElevW){cell_7_i[ElevW-1]}}, cell_7_i};
  assign e[7] = {{(NumW-ElevW){cell_8_i[ElevW-1]}}, cell_8_i};
  assign e[8] = {{(NumW-ElevW){cell_9_i[ElevW-1]}}, cell_9_i};

  always_comb begin
    sx      = (spacing_x_q == 16'd0) ? 16'd1 : spacing_x_q;
    sy      = (spacing_y_q == 16'd0) ? 16'd1 : spacing_y_q;
    maxdrop = 1'b0;
    case (method_q)
      METH_SSM: begin
        nx = (e[2] + (e[5] <<< 1) + e[8]) - (e[0] + (e[3] <<< 1) + e[6]);
        ny = (e[6] + (e[7] <<< 1) + e[8]) - (e[0] + (e[1] <<< 1) + e[2]);
        dx = DenW'({sx, 3'b000});
        dy = DenW'({sy, 3'b000});
      end
      METH_2FD: begin
        nx = e[5] - e[3];
        ny = e[7] - e[1];
        dx = DenW'({sx, 1'b0});
        dy = DenW'({sy, 1'b0});
      end
      METH_3FDWRD: begin
        nx = ((e[2] - e[0]) + (e[8] - e[6])) * $signed(NumW'(UnitQ16))
           + (e[5] - e[3]) * $signed(NumW'(Sqrt2Q16));
        ny = e[7] - e[1];
        dx = DenW'(sx) * DenW'(FdwrdDen);
        dy = DenW'({sy, 1'b0});
      end
      METH_3FD: begin
        nx = e[2] - e[0] + e[5] - e[3] + e[8] - e[6];
        ny = e[6] - e[0] + e[7] - e[1] + e[8] - e[2];
        dx = DenW'(sx) * DenW'(3'd6);
        dy = DenW'(sy) * DenW'(3'd6);
      end
      METH_FFD: begin
        nx = e[2] - e[0] + e[8] - e[6];
        ny = e[6] - e[0] + e[8] - e[2];
        dx = DenW'({sx, 2'b00});
        dy = DenW'({sy, 2'b00});
      end
      METH_MAXDROP: begin
        nx      = '0;
        ny      = '0;
        dx      = DenW'(sx);
        dy      = DenW'(sy);
        maxdrop = 1'b1;
      end
      METH_SIMPLE: begin
        nx = e[4] - e[3];
        ny = e[4] - e[1];
        dx = DenW'(sx);
        dy = DenW'(sy);
      end
      METH_QUAD: begin
        nx = e[5] + e[3] - (e[4] <<< 1);
        ny = e[7] + e[1] - (e[4] <<< 1);
        dx = (DenW'(sx) * DenW'(sx)) << 1;
        dy = (DenW'(sy) * DenW'(sy)) << 1;
      end
      default: begin
        nx = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
        ny = (e[6] - e[0]) + ((e[7] - e[1]) <<< 1) + (e[8] - e[2]);
        dx = DenW'({sx, 3'b000});
        dy = DenW'({sy, 3'b000});
      end
    endcase
    ax = nx[NumW-1] ? NumW'(-nx) : NumW'(nx);
    ay = ny[NumW-1] ? NumW'(-ny) : NumW'(ny);
  end

  always_comb begin
    vmax = '0;
    dk   = '0;
    vk   = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        dk = NumW'(e[4] - e[k]);
        dk = dk[NumW-1] ? NumW'(-dk) : dk;
        if (k == 0 || k == 2 || k == 6 || k == 8) begin
          vk = 32'(dk[15:0]) * 32'(Rsqrt2Q16);
        end else begin
          vk = {dk[15:0], 16'h0000};
        end
        if (vk > vmax) begin
          vmax = vk;
        end
      end
    end
  end

  assign in_ready_o       = !q_st_i.full;
  assign push_o           = in_valid_i && !q_st_i.full;
  assign entry_o.is_null  = (cell_5_i == null_q);
  assign entry_o.dvd_x    = maxdrop ? DvdW'(vmax) : {ax[MagW-1:0], {FracW{1'b0}}};
  assign entry_o.dvd_y    = maxdrop ? '0 : {ay[MagW-1:0], {FracW{1'b0}}};
  assign entry_o.den_x    = dx;
  assign entry_o.den_y    = dy;

endmodule

// ===== hdl/dsw_fifo.sv =====
module dsw_fifo import dsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dsw_entry_t entry_i,
  input  logic       pop_i,
  output dsw_entry_t entry_o,
  output q_status_t  status_o
);

  dsw_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QPtrW:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

  assign entry_o        = mem_q[rd_q];
  assign status_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== hdl/dsw_back.sv =====
module dsw_back import dsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_st_i,
  input  dsw_entry_t       entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DegW-1:0]  slope_degrees_o,
  output logic [PctW-1:0]  slope_percent_o,
  output logic [2:0]       slope_class_o,
  output logic [BinW-1:0]  hist_bin_o,
  output logic [31:0]      bin_count_o,
  output logic             is_null_o
);

  bk_state_e state_q, state_d;

  logic [CntW-1:0]       cnt_q;
  logic                  null_q;
  logic [DvdW-1:0]       qx_q, qy_q;
  logic [DenW-1:0]       rx_q, ry_q, denx_q, deny_q;
  logic [SqW-1:0]        sqx_q, sqy_q;
  logic [16:0]           unit_q;
  logic [RadW-1:0]       n_q, res_q, bit_q;
  logic signed [XW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic [DegW-1:0]       deg_q;
  logic [35:0]           prod_q;
  logic [2:0]            cls_q;
  logic [BinW-1:0]       bin_q;
  logic [CountW-1:0]     hist_q [HistBins];

  logic                  slot_free, load_out;
  logic [DenW:0]         shx, shy;
  logic                  gex, gey;
  logic [GradW-1:0]      gx, gy;
  logic [1:0]            sh;
  logic [ScW-1:0]        gxs, gys;
  logic [RadW:0]         trial;
  logic                  gen;
  logic [RadW-1:0]       n_d, res_d;
  logic signed [XW-1:0]  xs, ys;
  logic signed [ZW-1:0]  at;
  logic [22:0]           zc;
  logic [23:0]           zr;
  logic [17:0]           pm;
  logic [14:0]           t5;
  logic [BinW-1:0]       b1;
  logic [CountW-1:0]     cur, nxt;

  assign slot_free = !out_valid_o || out_ready_i;

  always_comb begin
    shx = {rx_q, qx_q[DvdW-1]};
    shy = {ry_q, qy_q[DvdW-1]};
    gex = shx >= {1'b0, denx_q};
    gey = shy >= {1'b0, deny_q};

    gx = qx_q[GradW-1:0];
    gy = qy_q[GradW-1:0];
    if (gx[GradW-1:GradW-2] != 2'b00 || gy[GradW-1:GradW-2] != 2'b00) begin
      sh = 2'd2;
    end else if (gx[ScW] || gy[ScW]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    gxs = ScW'(gx >> sh);
    gys = ScW'(gy >> sh);

    trial = {1'b0, res_q} + {1'b0, bit_q};
    gen   = {1'b0, n_q} >= trial;
    n_d   = gen ? RadW'({1'b0, n_q} - trial) : n_q;
    res_d = gen ? RadW'((res_q >> 1) + bit_q) : (res_q >> 1);

    xs = x_q >>> cnt_q[4:0];
    ys = y_q >>> cnt_q[4:0];
    at = $signed(AtanDegQ16[cnt_q[4:0]]);

    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > $signed(ZW'(Deg90Q16))) begin
      zc = Deg90Q16;
    end else begin
      zc = z_q[22:0];
    end
    zr = 24'(zc) + 24'd256;

    pm = 18'(deg_q) * 18'd20 + 18'd4;
    t5 = 15'(deg_q[DegW-1:7]) * 15'd205;
    b1 = t5[14:10] + 5'd1;

    cur = hist_q[bin_q];
    nxt = (cur == {CountW{1'b1}}) ? cur : cur + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_st_i.empty) begin
          state_d = entry_i.is_null ? BK_HIST : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == CntW'(DvdW - 1)) begin
          state_d = BK_SCALE;
        end
      end
      BK_SCALE: state_d = BK_SUM;
      BK_SUM:   state_d = BK_ROOT;
      BK_ROOT: begin
        if (cnt_q == CntW'(RootSteps - 1)) begin
          state_d = (res_d == '0) ? BK_CLAMP : BK_ROT;
        end
      end
      BK_ROT: begin
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = BK_CLAMP;
        end
      end
      BK_CLAMP: state_d = BK_MAP;
      BK_MAP:   state_d = BK_HIST;
      BK_HIST: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = !q_st_i.empty;
      BK_HIST: load_out = slot_free;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < HistBins; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_o   <= 1'b1;
        hist_q[bin_q] <= nxt;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        null_q <= entry_i.is_null;
        qx_q   <= entry_i.dvd_x;
        qy_q   <= entry_i.dvd_y;
        denx_q <= entry_i.den_x;
        deny_q <= entry_i.den_y;
        rx_q   <= '0;
        ry_q   <= '0;
        deg_q  <= '0;
        cls_q  <= '0;
        bin_q  <= BinTop;
        prod_q <= '0;
      end
      BK_DIV: begin
        rx_q <= gex ? DenW'(shx - {1'b0, denx_q}) : DenW'(shx);
        ry_q <= gey ? DenW'(shy - {1'b0, deny_q}) : DenW'(shy);
        qx_q <= {qx_q[DvdW-2:0], gex};
        qy_q <= {qy_q[DvdW-2:0], gey};
      end
      BK_SCALE: begin
        sqx_q  <= SqW'(gxs) * SqW'(gxs);
        sqy_q  <= SqW'(gys) * SqW'(gys);
        unit_q <= UnitQ16 >> sh;
      end
      BK_SUM: begin
        n_q   <= RadW'(sqx_q) + RadW'(sqy_q);
        res_q <= '0;
        bit_q <= {1'b1, {(RadW-1){1'b0}}};
      end
      BK_ROOT: begin
        n_q   <= n_d;
        res_q <= res_d;
        bit_q <= bit_q >> 2;
        x_q   <= $signed(XW'(unit_q));
        y_q   <= $signed(XW'(res_d));
        z_q   <= '0;
      end
      BK_ROT: begin
        if (y_q >= 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end
      end
      BK_CLAMP: deg_q <= zr[22:9];
      BK_MAP: begin
        prod_q <= 36'(pm) * 36'(Recip9);
        if (deg_q == '0) begin
          bin_q <= '0;
        end else begin
          bin_q <= (b1 > BinTop) ? BinTop : b1;
        end
        if (deg_q < 14'd256)       cls_q <= 3'd1;
        else if (deg_q < 14'd640)  cls_q <= 3'd2;
        else if (deg_q < 14'd1280) cls_q <= 3'd3;
        else if (deg_q < 14'd1920) cls_q <= 3'd4;
        else if (deg_q < 14'd3840) cls_q <= 3'd5;
        else if (deg_q < 14'd7680) cls_q <= 3'd6;
        else                       cls_q <= 3'd7;
      end
      default: begin
        null_q <= null_q;
      end
    endcase
    if (load_out) begin
      slope_degrees_o <= deg_q;
      slope_percent_o <= prod_q[35:21];
      slope_class_o   <= cls_q;
      hist_bin_o      <= bin_q;
      bin_count_o     <= 32'(nxt);
      is_null_o       <= null_q;
    end
  end

  a_null_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_null_o |-> slope_class_o == 3'd0 && hist_bin_o == BinTop)
    else $error("null beat with wrong class or bin");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slope_degrees_o <= 14'd11520 && hist_bin_o <= BinTop)
    else $error("degrees or bin out of range");

  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_null_o |->
      ((hist_bin_o == '0) == (slope_degrees_o == '0)) && slope_class_o != 3'd0)
    else $error("flat bin and degrees disagree");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q != BK_IDLE)
    else $error("pop without leaving idle");

endmodule

// ===== bench/dem_slope_window_tb.sv =====
module dem_slope_window_tb;
  import dsw_pkg::*;

  typedef logic signed [ElevW-1:0] window_t [9];

  typedef struct packed {
    logic [DegW-1:0] deg;
    logic [PctW-1:0] pct;
    logic [2:0]      cls;
    logic [BinW-1:0] bin;
    logic [31:0]     count;
    logic            is_null;
  } slope_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ElevW-1:0]    cell_i [9];
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_METHOD;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DegW-1:0]     slope_degrees_o;
  logic [PctW-1:0]     slope_percent_o;
  logic [2:0]          slope_class_o;
  logic [BinW-1:0]     hist_bin_o;
  logic [31:0]         bin_count_o;
  logic                is_null_o;

  slope_t      slope_q [$];
  int          errors = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  logic [3:0]  m_method;
  logic [15:0] m_sx;
  logic [15:0] m_sy;
  logic signed [ElevW-1:0] m_null;
  longint unsigned m_hist [HistBins];

  dem_slope_window dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cell_1_i(cell_i[0]), .cell_2_i(cell_i[1]), .cell_3_i(cell_i[2]),
    .cell_4_i(cell_i[3]), .cell_5_i(cell_i[4]), .cell_6_i(cell_i[5]),
    .cell_7_i(cell_i[6]), .cell_8_i(cell_i[7]), .cell_9_i(cell_i[8]),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_ready_i,
    .slope_degrees_o, .slope_percent_o, .slope_class_o,
    .hist_bin_o, .bin_count_o, .is_null_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 4000000);
    $display("dem_slope_window verification failed");
    $finish;
  end

  function automatic longint unsigned grad_q16(longint num, longint unsigned den);
    longint unsigned a;
    a = (num < 0) ? longint'(-num) : longint'(num);
    return (a / den) * 65536 + ((a % den) * 65536) / den;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned atan_deg_q7(longint unit, longint rise);
    longint x, y, z, nx, ny;
    x = unit;
    y = rise;
    z = 0;
    if (rise == 0) return 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(AtanDegQ16[i]);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(AtanDegQ16[i]);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return longint'((z + 256) >> 9);
  endfunction

  function automatic slope_t predict_slope(window_t w);
    longint c [10];
    longint unsigned sx, sy, gx, gy, unit, deg, pct, d, v;
    int cls, bin;
    logic nul;
    slope_t r;
    for (int k = 1; k <= 9; k++) c[k] = longint'(w[k-1]);
    sx = (m_sx == 0) ? 1 : m_sx;
    sy = (m_sy == 0) ? 1 : m_sy;
    gx = 0; gy = 0; unit = 65536; deg = 0; pct = 0; cls = 0;
    nul = (w[4] == m_null);
    if (nul) begin
      bin = 18;
    end else begin
      case (m_method)
        METH_SSM: begin
          gx = grad_q16((c[3] + 2*c[6] + c[9]) - (c[1] + 2*c[4] + c[7]), 8*sx);
          gy = grad_q16((c[7] + 2*c[8] + c[9]) - (c[1] + 2*c[2] + c[3]), 8*sy);
        end
        METH_2FD: begin
          gx = grad_q16(c[6] - c[4], 2*sx);
          gy = grad_q16(c[8] - c[2], 2*sy);
        end
        METH_3FDWRD: begin
          gx = grad_q16(((c[3] - c[1]) + (c[9] - c[7])) * 65536 +
                        (c[6] - c[4]) * 92682, 447508 * sx);
          gy = grad_q16(c[8] - c[2], 2*sy);
        end
        METH_3FD: begin
          gx = grad_q16(c[3] - c[1] + c[6] - c[4] + c[9] - c[7], 6*sx);
          gy = grad_q16(c[7] - c[1] + c[8] - c[2] + c[9] - c[3], 6*sy);
        end
        METH_FFD: begin
          gx = grad_q16(c[3] - c[1] + c[9] - c[7], 4*sx);
          gy = grad_q16(c[7] - c[1] + c[9] - c[3], 4*sy);
        end
        METH_MAXDROP: begin
          for (int k = 1; k <= 9; k++) begin
            if (k != 5) begin
              d = (c[5] >= c[k]) ? longint'(c[5] - c[k]) : longint'(c[k] - c[5]);
              if (k == 1 || k == 3 || k == 7 || k == 9) v = (d * 46341) / sx;
              else v = grad_q16(longint'(d), sx);
              if (v > gx) gx = v;
            end
          end
        end
        METH_SIMPLE: begin
          gx = grad_q16(c[5] - c[4], sx);
          gy = grad_q16(c[5] - c[2], sy);
        end
        METH_QUAD: begin
          gx = grad_q16(c[6] + c[4] - 2*c[5], 2*sx*sx);
          gy = grad_q16(c[8] + c[2] - 2*c[5], 2*sy*sy);
        end
        default: begin
          gx = grad_q16((c[3] - c[1]) + 2*(c[6] - c[4]) + (c[9] - c[7]), 8*sx);
          gy = grad_q16((c[7] - c[1]) + 2*(c[8] - c[2]) + (c[9] - c[3]), 8*sy);
        end
      endcase
      while (gx >= 64'h8000_0000 || gy >= 64'h8000_0000) begin
        gx >>= 1;
        gy >>= 1;
        unit >>= 1;
      end
      deg = atan_deg_q7(unit, int_sqrt(gx*gx + gy*gy));
      if (deg > 11520) deg = 11520;
      pct = (deg * 20 + 4) / 9;
      if (deg < 256) cls = 1;
      else if (deg < 640) cls = 2;
      else if (deg < 1280) cls = 3;
      else if (deg < 1920) cls = 4;
      else if (deg < 3840) cls = 5;
      else if (deg < 7680) cls = 6;
      else cls = 7;
      if (deg == 0) bin = 0;
      else begin
        bin = int'(deg / 640) + 1;
        if (bin > 18) bin = 18;
      end
    end
    if (m_hist[bin] < 64'hFFFF_FFFF) m_hist[bin]++;
    r.deg = deg[DegW-1:0];
    r.pct = pct[PctW-1:0];
    r.cls = cls[2:0];
    r.bin = bin[BinW-1:0];
    r.count = m_hist[bin][31:0];
    r.is_null = nul;
    return r;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    slope_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{slope_degrees_o, slope_percent_o, slope_class_o, hist_bin_o,
              bin_count_o, is_null_o};
      if (slope_q.size() == 0) begin
        $display("%0t unexpected beat got deg=%0d pct=%0d cls=%0d bin=%0d cnt=%0d null=%0d",
                 $time, got.deg, got.pct, got.cls, got.bin, got.count, got.is_null);
        errors++;
      end else begin
        want = slope_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch exp deg=%0d pct=%0d cls=%0d bin=%0d cnt=%0d null=%0d",
                   $time, want.deg, want.pct, want.cls, want.bin, want.count,
                   want.is_null);
          $display("%0t          got deg=%0d pct=%0d cls=%0d bin=%0d cnt=%0d null=%0d",
                   $time, got.deg, got.pct, got.cls, got.bin, got.count, got.is_null);
          errors++;
        end
      end
    end
  end

  task automatic send_window(window_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    for (int k = 0; k < 9; k++) cell_i[k] = w[k];
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    slope_q.push_back(predict_slope(w));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (slope_q.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_METHOD:    m_method = data[3:0];
      CFG_SPACING_X: m_sx = data;
      CFG_SPACING_Y: m_sy = data;
      default:       m_null = data;
    endcase
  endtask

  function automatic window_t fill_window(logic signed [ElevW-1:0] val);
    window_t w;
    foreach (w[k]) w[k] = val;
    return w;
  endfunction

  function automatic window_t random_window();
    window_t w;
    int kind, base, span, val;
    kind = $urandom_range(99);
    base = $urandom_range(65535) - 32768;
    case ($urandom_range(5))
      0: span = 1;
      1: span = 8;
      2: span = 100;
      3: span = 2000;
      4: span = 20000;
      default: span = 65535;
    endcase
    foreach (w[k]) begin
      if (kind < 15) begin
        w[k] = ElevW'($urandom);
      end else if (kind < 22) begin
        w[k] = ElevW'(base);
      end else begin
        val = base + $urandom_range(2 * span) - span;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        w[k] = ElevW'(val);
      end
    end
    if (kind >= 90) w[4] = m_null;
    return w;
  endfunction

  task automatic test_reset_defaults();
    window_t w;
    send_window(fill_window(16'sd0));
    send_window(fill_window(-16'sd32768));
    w = fill_window(16'sd32767);
    w[0] = -16'sd32768; w[3] = -16'sd32768; w[6] = -16'sd32768;
    send_window(w);
    w = fill_window(-16'sd32768);
    w[2] = 16'sd32767; w[4] = 16'sd0; w[8] = 16'sd32767;
    send_window(w);
    w = fill_window(16'sd100);
    w[5] = 16'sd101;
    send_window(w);
  endtask

  task automatic test_all_methods();
    window_t w;
    for (int m = 0; m < 16; m++) begin
      drain_results();
      write_reg(CFG_METHOD, 16'(m));
      w = fill_window(-16'sd32768);
      w[4] = 16'sd32767;
      w[m % 9] = (m % 9 == 4) ? 16'sd0 : 16'sd32767;
      w[(m + 5) % 9] = 16'sd1234;
      send_window(w);
    end
  endtask

  task automatic test_random_phases(int total);
    int per_phase;
    per_phase = total / 12;
    for (int p = 0; p < 12; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(CFG_SPACING_X, 16'd0);
          write_reg(CFG_SPACING_Y, 16'd65535);
        end
        1: begin
          write_reg(CFG_SPACING_X, 16'd65535);
          write_reg(CFG_SPACING_Y, 16'd0);
          write_reg(CFG_NULL_ELEV, 16'h7FFF);
        end
        2: begin
          write_reg(CFG_SPACING_X, 16'd1);
          write_reg(CFG_SPACING_Y, 16'd1);
          write_reg(CFG_NULL_ELEV, 16'h8000);
        end
        default: begin
          write_reg(CFG_SPACING_X,
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40)));
          write_reg(CFG_SPACING_Y,
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40)));
          write_reg(CFG_NULL_ELEV, 16'($urandom));
        end
      endcase
      write_reg(CFG_METHOD, (p < 9) ? 16'(p + 1) : 16'($urandom_range(15)));
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
        default: begin snd_idle_pct = 31; rcv_stall_pct = 31; end
      endcase
      for (int i = 0; i < per_phase; i++) send_window(random_window());
    end
  endtask

  initial begin
    foreach (cell_i[k]) cell_i[k] = '0;
    m_method = METH_HORN;
    m_sx = 16'd1;
    m_sy = 16'd1;
    m_null = -16'sd32768;
    foreach (m_hist[k]) m_hist[k] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_all_methods();
    test_random_phases(930);
    drain_results();
    if (errors == 0) begin
      $display("dem_slope_window verification clean");
    end else begin
      $display("dem_slope_window verification failed");
    end
    $finish;
  end

endmodule
